@@ sv/epf_pkg.sv @@
// ----------------------------------------------------------------------------
// epf_pkg
// Shared types and codes for the Euler path finder: request kinds,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package epf_pkg;

	// request kinds
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_WALK,
		ST_RELOAD,
		ST_FAIL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic add_edge;
		logic scan_start;
		logic scan_step;
		logic walk_init;
		logic push;
		logic pop;
		logic reload;
		logic emit_fail;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic scan_done;
		logic odd_gt2;
		logic can_push;
		logic sp_one;
	} sts_t;

endpackage

@@ sv/euler_path_finder.sv @@
// ----------------------------------------------------------------------------
// euler_path_finder
// Euler path search over an undirected graph held as an adjacency bit
// matrix; vertices stream out in post-order of a depth-first edge walk.
// ----------------------------------------------------------------------------
// sequence: an add request is taken when accepted; a run is accepted, scans each of the NODES
//   rows for degree parity and checks the odd count, then pushes each walked edge and emits each
//   vertex with a pop followed by a stack memory read to restore the top (no read after the final
//   vertex), or emits failure instead; each pop also waits while the output register is full
// throughput: one request at a time; the next is taken when the run ends,
//   while its final result may still wait in the output register
// reset: clears the adjacency matrix, stack pointer, controller and output
//   valid; the walk stack memory is not cleared and needs no clearing pass
module euler_path_finder #(
	parameter int NODES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [2:0] node_a,
	input  logic [2:0] node_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] vertex,
	output logic       found,
	output logic       last
);
	import epf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	epf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// matrix, stack and result
	epf_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.vertex    (vertex),
		.found     (found),
		.last      (last)
	);

endmodule

@@ sv/epf_ctrl.sv @@
// ----------------------------------------------------------------------------
// epf_ctrl
// Controller: accepts requests, sequences the degree scan and the
// depth-first walk, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module epf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  epf_pkg::sts_t sts,
	output epf_pkg::cmd_t cmd
);
	import epf_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_RUN) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						cmd.add_edge = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.odd_gt2) begin
					state_d = ST_FAIL;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.can_push) begin
					cmd.push = 1'b1;
				end else if (sts.out_free) begin
					cmd.pop = 1'b1;
					state_d = sts.sp_one ? ST_IDLE : ST_RELOAD;
				end
			end
			ST_RELOAD: begin
				cmd.reload = 1'b1;
				state_d    = ST_WALK;
			end
			ST_FAIL: begin
				if (sts.out_free) begin
					cmd.emit_fail = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/epf_dp.sv @@
// ----------------------------------------------------------------------------
// epf_dp
// Datapath: adjacency matrix, degree parity scan, walk stack memory with a
// separate top register, and the result register.
// ----------------------------------------------------------------------------
module epf_dp #(
	parameter int NODES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  epf_pkg::cmd_t cmd,
	output epf_pkg::sts_t sts,
	input  logic [2:0]    node_a,
	input  logic [2:0]    node_b,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    vertex,
	output logic          found,
	output logic          last
);
	import epf_pkg::*;

	localparam int VW    = $clog2(NODES);
	localparam int DEPTH = NODES * (NODES + 1) / 2 + 1;
	localparam int SPW   = $clog2(DEPTH + 1);
	localparam int AW    = $clog2(DEPTH);

	logic [NODES-1:0] adj_q [NODES];
	logic [VW-1:0]    scan_idx_q;
	logic [1:0]       odd_cnt_q;
	logic [VW-1:0]    start_q;
	logic [VW-1:0]    top_q;
	logic [SPW-1:0]   sp_q;
	logic [VW-1:0]    stack_mem [DEPTH];
	logic [VW-1:0]    rdata_q;
	logic             out_valid_q;
	logic [2:0]       vertex_q;
	logic             found_q;
	logic             last_q;

	logic             edge_ok;
	logic [VW-1:0]    a_idx;
	logic [VW-1:0]    b_idx;
	logic [NODES-1:0] scan_row;
	logic             row_odd;
	logic [NODES-1:0] walk_row;
	logic             has_next;
	logic [VW-1:0]    next_v;
	logic [SPW-1:0]   sp_m1;
	logic [SPW-1:0]   sp_m2;

	// edge endpoints
	assign edge_ok = (32'(node_a) < NODES) && (32'(node_b) < NODES);
	assign a_idx   = VW'(node_a);
	assign b_idx   = VW'(node_b);

	// degree parity of the scanned row, self-loop masked
	assign scan_row = adj_q[scan_idx_q] & ~(NODES'(1) << scan_idx_q);
	assign row_odd  = ^scan_row;

	// lowest neighbor of the stack top
	assign walk_row = adj_q[top_q];
	always_comb begin
		has_next = 1'b0;
		next_v   = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (walk_row[i]) begin
				has_next = 1'b1;
				next_v   = VW'(i);
			end
		end
	end

	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);

	// status
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.scan_done = (scan_idx_q == VW'(NODES - 1));
	assign sts.odd_gt2   = (odd_cnt_q == 2'd3);
	assign sts.can_push  = has_next && (sp_q < SPW'(DEPTH));
	assign sts.sp_one    = (sp_q == SPW'(1));

	// adjacency matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.add_edge && edge_ok) begin
			adj_q[a_idx][b_idx] <= 1'b1;
			adj_q[b_idx][a_idx] <= 1'b1;
		end else if (cmd.push) begin
			adj_q[top_q][next_v] <= 1'b0;
			adj_q[next_v][top_q] <= 1'b0;
		end
	end

	// degree scan and start vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			odd_cnt_q  <= '0;
			start_q    <= '0;
		end else if (cmd.scan_start) begin
			scan_idx_q <= '0;
			odd_cnt_q  <= '0;
			start_q    <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + VW'(1);
			if (row_odd) begin
				start_q <= scan_idx_q;
				if (odd_cnt_q != 2'd3) begin
					odd_cnt_q <= odd_cnt_q + 2'd1;
				end
			end
		end
	end

	// stack pointer and top of stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			top_q <= '0;
		end else if (cmd.walk_init) begin
			sp_q  <= SPW'(1);
			top_q <= start_q;
		end else if (cmd.push) begin
			sp_q  <= sp_q + SPW'(1);
			top_q <= next_v;
		end else if (cmd.pop) begin
			sp_q <= sp_m1;
		end else if (cmd.reload) begin
			top_q <= rdata_q;
		end
	end

	// entries below the top, registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[sp_m1[AW-1:0]] <= top_q;
		end
		if (cmd.pop && !sts.sp_one) begin
			rdata_q <= stack_mem[sp_m2[AW-1:0]];
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.emit_fail) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			vertex_q <= 3'(top_q);
			found_q  <= 1'b1;
			last_q   <= sts.sp_one;
		end else if (cmd.emit_fail) begin
			vertex_q <= 3'd0;
			found_q  <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign found     = found_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// stack never grows past its depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(DEPTH))
		else $error("walk stack pointer beyond depth");

	// pop only with a live stack
	a_pop_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (sp_q != '0))
		else $error("pop on empty walk stack");

	// push grows the stack by one
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (sp_q == $past(sp_q) + SPW'(1)))
		else $error("push did not advance stack pointer");

	// matrix stays symmetric
	for (genvar gi = 0; gi < NODES; gi++) begin : g_sym_i
		for (genvar gj = 0; gj < NODES; gj++) begin : g_sym_j
			a_sym: assert property (@(posedge clk) disable iff (!arst_n)
				adj_q[gi][gj] == adj_q[gj][gi])
				else $error("adjacency matrix lost symmetry");
		end
	end
`endif

endmodule
